>>> rtl/assert_macros.svh
// Assertion helpers; clk and rst_n of the enclosing module are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GBVD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GBVD_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define GBVD_ASSERT(lbl, prop, msg)
`define GBVD_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

>>> rtl/gbvd_pkg.sv
package gbvd_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int RADIUS_W        = 31;
  localparam int R2_W            = 2 * RADIUS_W;
  localparam int DIV_STEPS       = 32;
  localparam int QUO_W           = DIV_STEPS + 1;
  localparam int EXP_TABLE_DEPTH = 64;
  localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int EXP_W           = 33;

  typedef enum logic [2:0] {
    CFG_CENTER_X       = 3'd0,
    CFG_CENTER_Y       = 3'd1,
    CFG_CENTER_Z       = 3'd2,
    CFG_BRUSH_RADIUS   = 3'd3,
    CFG_BRUSH_STRENGTH = 3'd4
  } cfg_idx_t;

  // tuser bit positions of the result channel
  localparam int USER_INSIDE = 0;
  localparam int USER_SAT    = 1;

  typedef logic [EXP_W-1:0] exp_rom_t [0:EXP_TABLE_DEPTH];

  // exp(-k/(2*depth)) in Q1.32, truncated Taylor series
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t   rom;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
      x    = (64'(k) << 31) / EXP_TABLE_DEPTH;
      term = 64'd1 << 32;
      sum  = 64'd1 << 32;
      for (int n = 1; n < 40; n++) begin
        if (term != 64'd0) begin
          term = ((term * x) >> 32) / 64'(n);
          if (n % 2 == 1) sum = sum - term;
          else            sum = sum + term;
        end
      end
      rom[k] = sum[EXP_W-1:0];
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

>>> rtl/gbvd_div_pipe.sv
// Restoring divider, one quotient bit per stage, elastic valid chain.
module gbvd_div_pipe #(
  parameter int SIDE_W = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [gbvd_pkg::R2_W-1:0]     in_rem,
  input  logic                          in_quo,
  input  logic [SIDE_W-1:0]             in_side,
  input  logic [gbvd_pkg::R2_W-1:0]     r2,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [gbvd_pkg::QUO_W-1:0]    out_quo,
  output logic [SIDE_W-1:0]             out_side
);

  localparam int N  = gbvd_pkg::DIV_STEPS;
  localparam int RW = gbvd_pkg::R2_W;
  localparam int QW = gbvd_pkg::QUO_W;

  logic          v_r    [N];
  logic [RW-1:0] rem_r  [N];
  logic [QW-1:0] quo_r  [N];
  logic [SIDE_W-1:0] side_r [N];
  logic [N-1:0]  en;

  always_comb begin
    en[N-1] = !v_r[N-1] || out_ready;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[N-1];
  assign out_quo   = quo_r[N-1];
  assign out_side  = side_r[N-1];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic          v_src;
    logic [RW-1:0] rem_src;
    logic [QW-1:0] quo_src;
    logic [SIDE_W-1:0] side_src;
    logic [RW:0]   shifted;
    logic          ge;
    logic [RW:0]   diff;
    logic [RW-1:0] rem_nxt;
    logic [QW-1:0] quo_nxt;

    if (k == 0) begin : g_head
      assign v_src    = in_valid;
      assign rem_src  = in_rem;
      assign quo_src  = QW'(in_quo);
      assign side_src = in_side;
    end else begin : g_body
      assign v_src    = v_r[k-1];
      assign rem_src  = rem_r[k-1];
      assign quo_src  = quo_r[k-1];
      assign side_src = side_r[k-1];
    end

    always_comb begin
      shifted = {rem_src, 1'b0};
      ge      = shifted >= {1'b0, r2};
      diff    = shifted - {1'b0, r2};
      rem_nxt = ge ? diff[RW-1:0] : shifted[RW-1:0];
      quo_nxt = {quo_src[QW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k]  <= rem_nxt;
        quo_r[k]  <= quo_nxt;
        side_r[k] <= side_src;
      end
    end
  end

endmodule

>>> rtl/gaussian_brush_vertex_deform.sv
// Gaussian falloff brush: one vertex (x, y, z) in, one deformed height out.
// A vertex within brush_radius of the brush center gets
// strength * exp(-d2 / (2 r^2)) added to its y, saturated to the coordinate
// range; anything outside, and everything when the radius is zero, passes
// unchanged. All values are two's complement fixed point with a common
// scale. The datapath is a 43-stage elastic pipeline: one request per cycle
// while the output is not stalled. Most of its stages belong to the
// 33-step restoring divider that forms d2 / r^2 (one quotient bit per stage);
// the exponential is a 65-entry table with linear interpolation. Every
// stage carries its own valid and holds under stall, so a stalled output
// still lets the stages behind it fill up. Configuration (center, radius,
// strength) must only be written with the pipe empty.
`include "assert_macros.svh"

module gaussian_brush_vertex_deform #(
  parameter int COORD_WIDTH = gbvd_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request: vertex_x, vertex_y, vertex_z (low to high), zero padded
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]  in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // result: new_y, zero padded
  output logic [((COORD_WIDTH+7)/8)*8-1:0]    out_tdata,
  // result flags: inside_brush, saturated (low to high)
  output logic [1:0]                          out_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_we,
  input  logic [2:0]                          cfg_index,
  input  logic [((COORD_WIDTH > 31) ? COORD_WIDTH : 31)-1:0] cfg_wdata
);

  localparam int CW   = COORD_WIDTH;
  localparam int RADW = gbvd_pkg::RADIUS_W;
  localparam int AW   = (CW > RADW) ? CW : RADW;   // compare width
  localparam int RW   = gbvd_pkg::R2_W;
  localparam int D2W  = RW + 2;                     // sum of three squares
  localparam int QW   = gbvd_pkg::QUO_W;
  localparam int IXW  = gbvd_pkg::EXP_IDX_W;
  localparam int EW   = gbvd_pkg::EXP_W;
  localparam int PW   = 32 + IXW;
  localparam int SW   = (CW > 32) ? CW : 33;        // strength magnitude
  localparam int HW   = SW - 32;
  localparam int IW   = HW + 34;                    // influence magnitude
  localparam int NW   = IW + 1;                     // signed new height
  localparam int SIDE_W = CW + 1;
  localparam int OUT_TDATA_W = ((CW + 7) / 8) * 8;

  localparam logic signed [NW-1:0] YMAX = {{(NW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [NW-1:0] YMIN = {{(NW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  // configuration registers
  logic [CW-1:0]   center_x_r, center_y_r, center_z_r, strength_r;
  logic [RADW-1:0] radius_r;
  logic [RW-1:0]   r2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      center_z_r <= '0;
      radius_r   <= '0;
      strength_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gbvd_pkg::CFG_CENTER_X:       center_x_r <= cfg_wdata[CW-1:0];
        gbvd_pkg::CFG_CENTER_Y:       center_y_r <= cfg_wdata[CW-1:0];
        gbvd_pkg::CFG_CENTER_Z:       center_z_r <= cfg_wdata[CW-1:0];
        gbvd_pkg::CFG_BRUSH_RADIUS:   radius_r   <= cfg_wdata[RADW-1:0];
        gbvd_pkg::CFG_BRUSH_STRENGTH: strength_r <= cfg_wdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // r^2, refreshed each cycle; user changes radius only when idle (unenforced)
  always_ff @(posedge clk) begin
    r2_r <= radius_r * radius_r;
  end

  function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a,
                                             input logic [CW-1:0] b);
    logic signed [CW:0] d;
    d = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
    return d[CW] ? CW'(-d) : CW'(d);
  endfunction

  // ---------------------------------------------------------------------
  // stage enables: a stage loads when empty or when its successor moves
  // ---------------------------------------------------------------------
  logic v0_r, v1_r, v2_r, v3_r;
  logic vi_r, vr_r, vm_r, vf_r, vp_r, vs_r, vo_r;
  logic en0, en1, en2, en3;
  logic eni, enr, enm, enf, enp, ens, eno;
  logic div_in_ready, div_out_valid;

  assign eno = !vo_r || out_tready;
  assign ens = !vs_r || eno;
  assign enp = !vp_r || ens;
  assign enf = !vf_r || enp;
  assign enm = !vm_r || enf;
  assign enr = !vr_r || enm;
  assign eni = !vi_r || enr;
  assign en3 = !v3_r || div_in_ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign en0 = !v0_r || en1;

  assign in_tready = en0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0; v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
      vi_r <= 1'b0; vr_r <= 1'b0; vm_r <= 1'b0; vf_r <= 1'b0;
      vp_r <= 1'b0; vs_r <= 1'b0; vo_r <= 1'b0;
    end else begin
      if (en0) v0_r <= in_tvalid;
      if (en1) v1_r <= v0_r;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (eni) vi_r <= div_out_valid;
      if (enr) vr_r <= vi_r;
      if (enm) vm_r <= vr_r;
      if (enf) vf_r <= vm_r;
      if (enp) vp_r <= vf_r;
      if (ens) vs_r <= vp_r;
      if (eno) vo_r <= vs_r;
    end
  end

  // ---------------------------------------------------------------------
  // stage 0: axis distances, the per-axis outside test and the zero-radius test
  // ---------------------------------------------------------------------
  logic [CW-1:0]   vx, vy, vz, dxa, dya, dza;
  logic            pass0_nxt;
  logic [RADW-1:0] dx0_r, dy0_r, dz0_r;
  logic [CW-1:0]   y0_r;
  logic            pass0_r;

  assign vx = in_tdata[CW-1:0];
  assign vy = in_tdata[2*CW-1:CW];
  assign vz = in_tdata[3*CW-1:2*CW];

  always_comb begin
    dxa = abs_diff(vx, center_x_r);
    dya = abs_diff(vy, center_y_r);
    dza = abs_diff(vz, center_z_r);
    pass0_nxt = (radius_r == '0) || (AW'(dxa) > AW'(radius_r)) ||
                (AW'(dya) > AW'(radius_r)) || (AW'(dza) > AW'(radius_r));
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      dx0_r   <= RADW'(AW'(dxa));
      dy0_r   <= RADW'(AW'(dya));
      dz0_r   <= RADW'(AW'(dza));
      y0_r    <= vy;
      pass0_r <= pass0_nxt;
    end
  end

  // stage 1: squares
  logic [RW-1:0] sx1_r, sy1_r, sz1_r;
  logic [CW-1:0] y1_r;
  logic          pass1_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      sx1_r   <= dx0_r * dx0_r;
      sy1_r   <= dy0_r * dy0_r;
      sz1_r   <= dz0_r * dz0_r;
      y1_r    <= y0_r;
      pass1_r <= pass0_r;
    end
  end

  // stage 2: d2
  logic [D2W-1:0] d2_r;
  logic [CW-1:0]  y2_r;
  logic           pass2_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      d2_r    <= D2W'(sx1_r) + D2W'(sy1_r) + D2W'(sz1_r);
      y2_r    <= y1_r;
      pass2_r <= pass1_r;
    end
  end

  // stage 3: rim test and integer quotient bit (d2 == r2 on the rim)
  logic [D2W-1:0] d2_less;
  logic           q0_nxt, pass3_nxt;
  logic [RW-1:0]  rem3_r;
  logic           q3_r;
  logic [CW-1:0]  y3_r;
  logic           pass3_r;

  always_comb begin
    pass3_nxt = pass2_r || (d2_r > D2W'(r2_r));
    q0_nxt    = d2_r >= D2W'(r2_r);
    d2_less   = d2_r - D2W'(r2_r);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      rem3_r  <= q0_nxt ? d2_less[RW-1:0] : d2_r[RW-1:0];
      q3_r    <= q0_nxt;
      y3_r    <= y2_r;
      pass3_r <= pass3_nxt;
    end
  end

  // stages 4..35: fractional quotient bits of d2 / r2
  logic [QW-1:0]     div_quo;
  logic [SIDE_W-1:0] div_side;

  gbvd_div_pipe #(
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3_r),
    .in_ready  (div_in_ready),
    .in_rem    (rem3_r),
    .in_quo    (q3_r),
    .in_side   ({pass3_r, y3_r}),
    .r2        (r2_r),
    .out_valid (div_out_valid),
    .out_ready (eni),
    .out_quo   (div_quo),
    .out_side  (div_side)
  );

  // ---------------------------------------------------------------------
  // stage I: table index and weight from a = ratio / 2
  // ---------------------------------------------------------------------
  logic [PW-1:0]  p_val;
  logic [IXW:0]   idx_full;
  logic [IXW-1:0] idx_r;
  logic           last_r;
  logic [30:0]    wgt_i_r;
  logic [CW-1:0]  yi_r;
  logic           passi_r;

  always_comb begin
    p_val    = PW'(div_quo[QW-1:1]) * PW'(gbvd_pkg::EXP_TABLE_DEPTH);
    idx_full = p_val[PW-1:31];
  end

  always_ff @(posedge clk) begin
    if (eni) begin
      idx_r   <= idx_full[IXW-1:0];
      last_r  <= idx_full >= (IXW+1)'(gbvd_pkg::EXP_TABLE_DEPTH);
      wgt_i_r <= p_val[30:0];
      yi_r    <= div_side[CW-1:0];
      passi_r <= div_side[CW];
    end
  end

  // stage R: table lookups; at the last index the slope is zero
  logic [IXW-1:0] idx_next;
  logic [EW-1:0]  e_lo_r, e_dif_r;
  logic [30:0]    wgt_r_r;
  logic [CW-1:0]  yr_r;
  logic           passr_r;

  assign idx_next = last_r ? idx_r : idx_r + IXW'(1);

  always_ff @(posedge clk) begin
    if (enr) begin
      e_lo_r  <= gbvd_pkg::EXP_ROM[idx_r];
      e_dif_r <= gbvd_pkg::EXP_ROM[idx_r] - gbvd_pkg::EXP_ROM[idx_next];
      wgt_r_r <= wgt_i_r;
      yr_r    <= yi_r;
      passr_r <= passi_r;
    end
  end

  // stage M: slope times weight
  logic [63:0]   slope_m_r;
  logic [EW-1:0] e_m_r;
  logic [CW-1:0] ym_r;
  logic          passm_r;

  always_ff @(posedge clk) begin
    if (enm) begin
      slope_m_r <= e_dif_r * wgt_r_r;
      e_m_r     <= e_lo_r;
      ym_r      <= yr_r;
      passm_r   <= passr_r;
    end
  end

  // stage F: falloff
  logic [63:0]   slope_sh;
  logic [EW-1:0] f_r;
  logic [CW-1:0] yf_r;
  logic          passf_r;

  assign slope_sh = slope_m_r >> 31;

  always_ff @(posedge clk) begin
    if (enf) begin
      f_r     <= e_m_r - slope_sh[EW-1:0];
      yf_r    <= ym_r;
      passf_r <= passm_r;
    end
  end

  // stage P: |strength| times falloff, split at bit 32
  logic          s_neg;
  logic [CW-1:0] s_abs;
  logic [SW-1:0] s_abs_w;
  logic [HW+EW-1:0] mag_hi_r;
  logic [32+EW-1:0] mag_lo_r;
  logic [CW-1:0] yp_r;
  logic          passp_r;

  always_comb begin
    s_neg   = strength_r[CW-1];
    s_abs   = s_neg ? (~strength_r + CW'(1)) : strength_r;
    s_abs_w = SW'(s_abs);
  end

  always_ff @(posedge clk) begin
    if (enp) begin
      mag_hi_r <= s_abs_w[SW-1:32] * f_r;
      mag_lo_r <= s_abs_w[31:0] * f_r;
      yp_r     <= yf_r;
      passp_r  <= passf_r;
    end
  end

  // stage S: influence, rounded half away from zero
  logic [32+EW:0] lo_rnd;
  logic [IW-1:0]  infl_r;
  logic [CW-1:0]  ys_r;
  logic           passs_r;

  assign lo_rnd = (32+EW+1)'(mag_lo_r) + (32+EW+1)'(33'h0_8000_0000);

  always_ff @(posedge clk) begin
    if (ens) begin
      infl_r  <= IW'(mag_hi_r) + IW'(lo_rnd[32+EW:32]);
      ys_r    <= yp_r;
      passs_r <= passp_r;
    end
  end

  // stage O: apply, saturate, output register
  logic signed [NW-1:0] y_ext, infl_ext, ny;
  logic [CW-1:0] new_y_nxt, new_y_r;
  logic          inside_nxt, sat_nxt, inside_r, sat_r;

  always_comb begin
    y_ext    = $signed({{(NW-CW){ys_r[CW-1]}}, ys_r});
    infl_ext = $signed(NW'(infl_r));
    ny       = s_neg ? (y_ext - infl_ext) : (y_ext + infl_ext);
    new_y_nxt  = ys_r;
    inside_nxt = 1'b0;
    sat_nxt    = 1'b0;
    if (!passs_r) begin
      inside_nxt = 1'b1;
      priority if (ny > YMAX) begin
        new_y_nxt = YMAX[CW-1:0];
        sat_nxt   = 1'b1;
      end else if (ny < YMIN) begin
        new_y_nxt = YMIN[CW-1:0];
        sat_nxt   = 1'b1;
      end else begin
        new_y_nxt = ny[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (eno) begin
      new_y_r  <= new_y_nxt;
      inside_r <= inside_nxt;
      sat_r    <= sat_nxt;
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = OUT_TDATA_W'(new_y_r);
  assign out_tuser  = {sat_r, inside_r};

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  `GBVD_ASSERT(a_sat_only_inside, (out_tvalid && out_tuser[gbvd_pkg::USER_SAT]) |-> out_tuser[gbvd_pkg::USER_INSIDE], "saturated result outside brush")
  `GBVD_ASSERT(a_sat_at_limit, (out_tvalid && out_tuser[gbvd_pkg::USER_SAT]) |-> (new_y_r == YMAX[CW-1:0] || new_y_r == YMIN[CW-1:0]), "saturated height not at range limit")
  `GBVD_ASSERT(a_lookup_holds, (vi_r && !eni) |=> (vi_r && $stable(idx_r)), "stalled lookup stage lost its request")
  `GBVD_ASSERT(a_out_holds, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)), "stalled result changed")

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the Gaussian falloff brush vertex deform block.
// One vertex request in, one deformed height out. The expected height and
// flags are computed here from the configured brush at the moment each
// request is accepted, and compared in order with the results.
module tb_top;

  localparam int DEPTH      = 64;
  localparam int DRAIN_CYC  = 60;    // a bit over the 43-stage pipe
  localparam int STALL_MAX  = 5000;  // cycles with no handshake or config write
  localparam longint CMIN   = -64'sd2147483648;
  localparam longint CMAX   = 64'sd2147483647;

  typedef struct packed {
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
  } vertex_t;

  typedef struct packed {
    logic [31:0] new_y;
    logic        in_brush;
    logic        sat;
  } height_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic [95:0]  in_tdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [31:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic         cfg_we = 1'b0;
  gbvd_pkg::cfg_idx_t cfg_index = gbvd_pkg::CFG_CENTER_X;
  logic [31:0]  cfg_wdata = '0;

  gaussian_brush_vertex_deform dut (
    .clk, .rst_n,
    .in_tdata, .in_tvalid, .in_tready,
    .out_tdata, .out_tuser, .out_tvalid, .out_tready,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // brush as programmed
  logic signed [31:0] brush_cx, brush_cy, brush_cz, brush_str;
  logic [30:0]        brush_r;
  longint unsigned    falloff_rom [0:DEPTH];

  vertex_t vertex_q[$];     // requests waiting to be offered
  height_t height_q[$];     // heights waiting to come out
  int      errors = 0;
  int      snd_idle_pct = 0;
  int      rcv_idle_pct = 0;
  bit      send_pause = 1'b0;
  bit      hold_go = 1'b0;
  bit      hold_ack = 1'b0;
  int      hold_cnt = 0;
  bit      in_took = 1'b0;
  int      quiet_cyc = 0;

  // exp(-k/(2*DEPTH)) in Q1.32 by the truncated Taylor series
  function automatic void fill_falloff_rom();
    longint unsigned x, term, sum;
    for (int k = 0; k <= DEPTH; k++) begin
      x    = (longint'(k) << 31) / DEPTH;
      term = 64'd1 << 32;
      sum  = 64'd1 << 32;
      for (int n = 1; n < 40 && term != 0; n++) begin
        term = ((term * x) >> 32) / n;
        if (n % 2 == 1) sum -= term;
        else            sum += term;
      end
      falloff_rom[k] = sum;
    end
  endfunction

  function automatic longint unsigned axis_dist(longint a, longint b);
    longint d;
    d = a - b;
    return (d < 0) ? -d : d;
  endfunction

  function automatic height_t deform_height(vertex_t v);
    height_t         h;
    longint          y, ny, s;
    longint unsigned r, dx, dy, dz, d2, r2, rem, ratio, p, idx, w, f, s_abs, infl;
    y  = longint'(signed'(v.vy));
    r  = brush_r;
    dx = axis_dist(longint'(signed'(v.vx)), longint'(brush_cx));
    dy = axis_dist(y, longint'(brush_cy));
    dz = axis_dist(longint'(signed'(v.vz)), longint'(brush_cz));
    h  = '{new_y: v.vy, in_brush: 1'b0, sat: 1'b0};
    if (r == 0 || dx > r || dy > r || dz > r) return h;
    d2 = dx * dx + dy * dy + dz * dz;
    r2 = r * r;
    if (d2 > r2) return h;
    // restoring division, Q1.32 quotient
    ratio = 0;
    rem   = d2;
    if (rem >= r2) begin
      ratio = 1;
      rem  -= r2;
    end
    for (int i = 0; i < 32; i++) begin
      rem   = rem << 1;
      ratio = ratio << 1;
      if (rem >= r2) begin
        rem  -= r2;
        ratio |= 1;
      end
    end
    p   = (ratio >> 1) * DEPTH;
    idx = p >> 31;
    w   = p & 64'h7FFF_FFFF;
    if (idx >= DEPTH) f = falloff_rom[DEPTH];
    else f = falloff_rom[idx] - (((falloff_rom[idx] - falloff_rom[idx+1]) * w) >> 31);
    s     = longint'(brush_str);
    s_abs = (s < 0) ? -s : s;
    // strength * falloff, rounded half away from zero
    infl  = (s_abs >> 32) * f + ((((s_abs & 64'hFFFF_FFFF) * f) + 64'h8000_0000) >> 32);
    ny    = (s < 0) ? y - longint'(infl) : y + longint'(infl);
    h.in_brush = 1'b1;
    if (ny > CMAX) begin
      ny = CMAX;
      h.sat = 1'b1;
    end else if (ny < CMIN) begin
      ny = CMIN;
      h.sat = 1'b1;
    end
    h.new_y = ny[31:0];
    return h;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    errors++;
  endtask

  // Request driver: valid holds until the handshake, then the next vertex
  // may follow at once or after a random gap.
  always @(negedge clk) begin
    vertex_t nv;
    if (rst_n && (!in_tvalid || in_took)) begin
      if (vertex_q.size() > 0 && !send_pause && $urandom_range(0, 99) >= snd_idle_pct) begin
        nv        = vertex_q.pop_front();
        in_tdata  <= {nv.vz, nv.vy, nv.vx};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor and request bookkeeping; all sampling is on the rising edge.
  always @(posedge clk) begin
    height_t want;
    vertex_t got_v;
    in_took = in_tvalid && in_tready;
    if (in_took) begin
      got_v = '{vx: in_tdata[31:0], vy: in_tdata[63:32], vz: in_tdata[95:64]};
      height_q.push_back(deform_height(got_v));
    end
    if (out_tvalid && out_tready) begin
      if (height_q.size() == 0) begin
        report("unexpected result", out_tdata, 32'h0);
      end else begin
        want = height_q.pop_front();
        if (out_tdata !== want.new_y) report("new_y", out_tdata, want.new_y);
        if (out_tuser[gbvd_pkg::USER_INSIDE] !== want.in_brush)
          report("inside_brush", 32'(out_tuser[gbvd_pkg::USER_INSIDE]), 32'(want.in_brush));
        if (out_tuser[gbvd_pkg::USER_SAT] !== want.sat)
          report("saturated", 32'(out_tuser[gbvd_pkg::USER_SAT]), 32'(want.sat));
      end
    end
    // watchdog
    if (in_took || (out_tvalid && out_tready) || cfg_we || !rst_n) quiet_cyc = 0;
    else quiet_cyc++;
    if (quiet_cyc >= STALL_MAX) begin
      $display("timeout: no handshake for %0d cycles", STALL_MAX);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_go != hold_ack) begin
      hold_ack   <= hold_go;
      hold_cnt   <= 400;
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt   <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  task automatic write_reg(gbvd_pkg::cfg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      gbvd_pkg::CFG_CENTER_X:       brush_cx  = val;
      gbvd_pkg::CFG_CENTER_Y:       brush_cy  = val;
      gbvd_pkg::CFG_CENTER_Z:       brush_cz  = val;
      gbvd_pkg::CFG_BRUSH_RADIUS:   brush_r   = val[30:0];
      gbvd_pkg::CFG_BRUSH_STRENGTH: brush_str = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_brush(logic [31:0] cx, cy, cz, r, s);
    write_reg(gbvd_pkg::CFG_CENTER_X, cx);
    write_reg(gbvd_pkg::CFG_CENTER_Y, cy);
    write_reg(gbvd_pkg::CFG_CENTER_Z, cz);
    write_reg(gbvd_pkg::CFG_BRUSH_RADIUS, r);
    write_reg(gbvd_pkg::CFG_BRUSH_STRENGTH, s);
  endtask

  // pipe empty and nothing owed, then let the last stages settle
  task automatic wait_idle();
    wait (vertex_q.size() == 0 && !in_tvalid && height_q.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic push_vertex(logic [31:0] x, y, z);
    vertex_q.push_back('{vx: x, vy: y, vz: z});
  endtask

  // signed offset of up to the radius, sometimes much smaller
  function automatic logic [31:0] near(logic [31:0] c);
    longint unsigned m;
    longint          o;
    m = longint'(brush_r) >> $urandom_range(0, 3);
    o = longint'({$urandom, $urandom} % (2 * m + 1)) - longint'(m);
    return c + o[31:0];
  endfunction

  task automatic random_vertices(int n);
    logic [31:0] x, y, z;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 70) begin
        x = near(brush_cx);
        y = near(brush_cy);
        z = near(brush_cz);
        // heights near the range limits to reach saturation
        if ($urandom_range(0, 9) == 0) y = $urandom_range(0, 1) ? 32'h7FFF_FF00 : 32'h8000_0100;
      end else begin
        x = $urandom;
        y = $urandom;
        z = $urandom;
      end
      push_vertex(x, y, z);
    end
  endtask

  initial begin
    brush_cx = '0; brush_cy = '0; brush_cz = '0; brush_r = '0; brush_str = '0;
    fill_falloff_rom();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: radius zero after reset passes everything.
    push_vertex(32'h0, 32'h0, 32'h0);
    push_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    wait_idle();

    // unit radius at origin, unit strength
    set_brush(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000);
    push_vertex(32'h0, 32'h0, 32'h0);                 // center, full strength
    push_vertex(32'h0001_0000, 32'h0, 32'h0);         // rim, counts as inside
    push_vertex(32'h0001_0001, 32'h0, 32'h0);         // just outside
    push_vertex(32'h0000_B505, 32'h0000_B505, 32'h0); // corner region
    push_vertex(32'h0, 32'h0, 32'hFFFF_0000);         // rim on z
    push_vertex(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    push_vertex(32'h0, 32'h0, 32'h0002_0000);         // one axis beyond radius
    wait_idle();

    // max radius, max strength: overflow high
    set_brush(32'h0, 32'h7FFF_0000, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_vertex(32'h0, 32'h7FFF_FFFF, 32'h0);
    push_vertex(32'h0, 32'h7FFF_0000, 32'h0);
    push_vertex(32'h7FFF_FFFF, 32'h0, 32'h8000_0000);
    push_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    wait_idle();

    // min strength at the low corner: overflow low
    set_brush(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    push_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_vertex(32'hFFFF_FFFF, 32'h8000_1000, 32'hFFFF_FFFF);
    push_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    push_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    wait_idle();

    // Random phases, cycling through the idling modes.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  end
        1: begin snd_idle_pct = 76; rcv_idle_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_idle_pct = 76; end
        default: begin snd_idle_pct = 25; rcv_idle_pct = 25; end
      endcase
      case (ph)
        3: set_brush(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, $urandom);
        5: set_brush($urandom, $urandom, $urandom, 32'h0, $urandom);
        6: set_brush($urandom, $urandom, $urandom, 32'h0000_0001, $urandom);
        default: set_brush($urandom, $urandom, $urandom,
                           $urandom >> $urandom_range(1, 24), $urandom);
      endcase
      random_vertices(110);
      if (ph == 0) begin
        // long receiver hold-off while requests keep coming
        hold_go = ~hold_go;
        random_vertices(100);
      end
      if (ph == 4) begin
        // sender pause until every result is back
        wait (vertex_q.size() < 50);
        send_pause = 1'b1;
        wait (!in_tvalid && height_q.size() == 0);
        repeat (20) @(posedge clk);
        send_pause = 1'b0;
      end
      wait_idle();
    end

    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

>>> gaussian_brush_vertex_deform.f
+incdir+rtl
rtl/gbvd_pkg.sv
rtl/gbvd_div_pipe.sv
rtl/gaussian_brush_vertex_deform.sv
verif/tb_top.sv
